/* rtl/core/alws_pkg.sv */
package alws_pkg;

  localparam int DEFAULT_LIST_DEPTH = 8;

  localparam int KIND_W    = 4;
  localparam int KEY_W     = 64;
  localparam int PRICE_W   = 32;
  localparam int QTY_W     = 32;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 4'd0,
    KIND_INS_AT    = 4'd1,
    KIND_APPEND    = 4'd2,
    KIND_REM_AT    = 4'd3,
    KIND_REM_KEY   = 4'd4,
    KIND_FIND      = 4'd5,
    KIND_UPD_QTY   = 4'd6,
    KIND_READ      = 4'd7,
    KIND_CLEAR     = 4'd8
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_NOKEY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_SETQ = 2'd3
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PRICE_W-1:0]      price;
    logic signed [QTY_W-1:0] quantity;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [KEY_W-1:0]        key;
    logic [PRICE_W-1:0]      price;
    logic signed [QTY_W-1:0] quantity;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        found_index;
    logic [KEY_W-1:0]        entry_key;
    logic [PRICE_W-1:0]      entry_price;
    logic signed [QTY_W-1:0] entry_quantity;
    logic [CNT_OUT_W-1:0]    entry_count;
  } out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t             op;
    logic [POS_W-1:0]     target;
    logic [CNT_OUT_W-1:0] count;
  } cell_ctrl_t;

endpackage

/* rtl/core/array_list_with_shift_core.sv */
// Bounded ordered list held in a chain of cells, packed from index 0.
// Input channel: a command transaction (kind, key, price, quantity, position)
// is taken on a rising edge with start high and busy low. busy is high for
// the one cycle in which the command executes.
// Result channel: exactly one result per command. out_strobe is high for one
// cycle and out_data is valid only in that cycle; the receiver cannot stall,
// so nothing waits on it.
// Sequence: the result is registered at the end of the execute cycle and shown
// on the ports for one cycle. A new command may be accepted at the edge that
// ends the result cycle, overlapping that result but never an execution. The
// accepting cycle compares the key against every cell and registers the match
// vector; the execute cycle encodes the first match, selects the reported
// entry and shifts the chain in one step.
// Reset: synchronous, active low; empties the list and drops any command in
// flight. Cell contents are not cleared, only entries below the count are
// ever read.
module array_list_with_shift_core #(
  parameter int LIST_DEPTH = alws_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  alws_pkg::in_t   in_data,
  output logic            out_strobe,
  output alws_pkg::out_t  out_data
);

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  alws_pkg::fsm_t        state_r, state_nxt;
  alws_pkg::in_t         cmd_r;
  logic [LIST_DEPTH-1:0] match_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  strobe_r;
  alws_pkg::out_t        out_r, out_nxt;

  alws_pkg::entry_t      entries [LIST_DEPTH];
  alws_pkg::entry_t      left_w  [LIST_DEPTH];
  alws_pkg::entry_t      right_w [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match_w;
  logic [LIST_DEPTH-1:0] valid_w;
  alws_pkg::entry_t      new_w;
  alws_pkg::cell_ctrl_t  ctrl_w;
  logic                  accept;

  assign busy   = (state_r == alws_pkg::FSM_EXEC);
  assign accept = start && !busy;
  assign new_w  = '{key: cmd_r.key, price: cmd_r.price, quantity: cmd_r.quantity};

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = entries[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = entries[g+1];
    end
    assign valid_w[g] = (CNT_W'(g) < count_r);

    alws_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctrl_i    (ctrl_w),
      .cmp_key_i (in_data.key),
      .new_i     (new_w),
      .left_i    (left_w[g]),
      .right_i   (right_w[g]),
      .entry_o   (entries[g]),
      .match_o   (match_w[g])
    );
  end

  function automatic logic [IDX_W-1:0] first_hit(input logic [LIST_DEPTH-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (m[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  // execute step
  logic                          hit;
  logic [alws_pkg::POS_W-1:0]    hit_pos;
  logic                          pos_ok;
  logic                          full;
  logic                          have;
  logic [alws_pkg::POS_W-1:0]    target;
  alws_pkg::status_t             status;
  alws_pkg::cell_op_t            op;
  alws_pkg::entry_t              rd;

  assign hit     = |match_r;
  assign hit_pos = alws_pkg::POS_W'(first_hit(match_r));
  assign pos_ok  = alws_pkg::CNT_OUT_W'(cmd_r.position) < alws_pkg::CNT_OUT_W'(count_r);
  assign full    = (count_r == DEPTH_C);
  assign rd      = entries[target[IDX_W-1:0]];

  always_comb begin
    state_nxt = state_r;
    op        = alws_pkg::CELL_HOLD;
    target    = '0;
    status    = alws_pkg::STATUS_OK;
    have      = 1'b0;
    count_nxt = count_r;
    case (state_r)
      alws_pkg::FSM_IDLE: begin
        if (accept) state_nxt = alws_pkg::FSM_EXEC;
      end
      alws_pkg::FSM_EXEC: begin
        state_nxt = alws_pkg::FSM_IDLE;
        case (cmd_r.kind)
          alws_pkg::KIND_INS_FRONT, alws_pkg::KIND_INS_AT, alws_pkg::KIND_APPEND: begin
            if (full) begin
              status = alws_pkg::STATUS_FULL;
            end else if (cmd_r.kind == alws_pkg::KIND_INS_AT && !pos_ok) begin
              status = alws_pkg::STATUS_BADPOS;
            end else begin
              op        = alws_pkg::CELL_INS;
              count_nxt = count_r + CNT_W'(1);
              if (cmd_r.kind == alws_pkg::KIND_INS_AT) begin
                target = cmd_r.position;
              end else if (cmd_r.kind == alws_pkg::KIND_APPEND) begin
                target = alws_pkg::POS_W'(count_r);
              end
            end
          end
          alws_pkg::KIND_REM_AT, alws_pkg::KIND_READ: begin
            if (!pos_ok) begin
              status = alws_pkg::STATUS_BADPOS;
            end else begin
              target = cmd_r.position;
              have   = 1'b1;
              if (cmd_r.kind == alws_pkg::KIND_REM_AT) begin
                op        = alws_pkg::CELL_DEL;
                count_nxt = count_r - CNT_W'(1);
              end
            end
          end
          alws_pkg::KIND_REM_KEY, alws_pkg::KIND_FIND, alws_pkg::KIND_UPD_QTY: begin
            if (!hit) begin
              status = alws_pkg::STATUS_NOKEY;
            end else begin
              target = hit_pos;
              have   = 1'b1;
              if (cmd_r.kind == alws_pkg::KIND_REM_KEY) begin
                op        = alws_pkg::CELL_DEL;
                count_nxt = count_r - CNT_W'(1);
              end else if (cmd_r.kind == alws_pkg::KIND_UPD_QTY) begin
                op = alws_pkg::CELL_SETQ;
              end
            end
          end
          alws_pkg::KIND_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            op = alws_pkg::CELL_HOLD;
          end
        endcase
      end
      default: begin
        state_nxt = alws_pkg::FSM_IDLE;
      end
    endcase
  end

  assign ctrl_w = '{op: op, target: target, count: alws_pkg::CNT_OUT_W'(count_r)};

  always_comb begin
    out_nxt             = '0;
    out_nxt.status      = status;
    out_nxt.entry_count = alws_pkg::CNT_OUT_W'(count_nxt);
    if (have) begin
      out_nxt.found_index = target;
      out_nxt.entry_key   = rd.key;
      out_nxt.entry_price = rd.price;
      // update reports the quantity just written
      out_nxt.entry_quantity = (cmd_r.kind == alws_pkg::KIND_UPD_QTY) ?
                               cmd_r.quantity : rd.quantity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= alws_pkg::FSM_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= busy;
      if (busy) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_data;
      match_r <= match_w & valid_w;
    end
    if (busy) out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("list count beyond depth");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_strobe && !busy))
    else $error("executed command gave no result");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == alws_pkg::STATUS_FULL) |->
      (out_data.entry_count == alws_pkg::CNT_OUT_W'(LIST_DEPTH)))
    else $error("full status with list not full");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status != alws_pkg::STATUS_OK) |->
      (out_data.found_index == '0 && out_data.entry_key == '0))
    else $error("failed transaction reports an entry");

endmodule

/* rtl/core/alws_cell.sv */
module alws_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  alws_pkg::cell_ctrl_t          ctrl_i,
  input  logic [alws_pkg::KEY_W-1:0]    cmp_key_i,
  input  alws_pkg::entry_t              new_i,
  input  alws_pkg::entry_t              left_i,
  input  alws_pkg::entry_t              right_i,
  output alws_pkg::entry_t              entry_o,
  output logic                          match_o
);

  localparam logic [alws_pkg::CNT_OUT_W-1:0] MY      = alws_pkg::CNT_OUT_W'(IDX);
  localparam logic [alws_pkg::CNT_OUT_W-1:0] MY_NEXT = alws_pkg::CNT_OUT_W'(IDX + 1);

  alws_pkg::entry_t                  entry_r;
  logic [alws_pkg::CNT_OUT_W-1:0]    tgt;

  assign tgt = alws_pkg::CNT_OUT_W'(ctrl_i.target);

  always_ff @(posedge clk) begin
    case (ctrl_i.op)
      alws_pkg::CELL_INS: begin
        if (MY == tgt) begin
          entry_r <= new_i;
        end else if (MY > tgt && MY <= ctrl_i.count) begin
          entry_r <= left_i;
        end
      end
      alws_pkg::CELL_DEL: begin
        // close the gap: take from the upper neighbor
        if (MY >= tgt && MY_NEXT < ctrl_i.count) begin
          entry_r <= right_i;
        end
      end
      alws_pkg::CELL_SETQ: begin
        if (MY == tgt) begin
          entry_r.quantity <= new_i.quantity;
        end
      end
      default: begin
        entry_r <= entry_r;
      end
    endcase
  end

  assign entry_o = entry_r;
  assign match_o = (entry_r.key == cmp_key_i);

endmodule

/* sim/array_list_with_shift_core_test.sv */
module array_list_with_shift_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = alws_pkg::DEFAULT_LIST_DEPTH;
  localparam int RANDOM_CMDS = 1900;
  localparam int KEY_POOL_N = 12;
  localparam int STALL_LIMIT = 500;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 10;
  localparam logic [alws_pkg::KIND_W-1:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [alws_pkg::KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  alws_pkg::in_t in_data = '0;
  logic out_strobe;
  alws_pkg::out_t out_data;

  array_list_with_shift_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow copy of the list
  alws_pkg::entry_t shadow_entries[LIST_DEPTH];
  int shadow_count = 0;

  alws_pkg::in_t cmd_backlog[$];
  alws_pkg::out_t due_replies[$];
  logic [alws_pkg::KEY_W-1:0] key_pool[KEY_POOL_N];

  int cmd_total = 0;
  int accepted_total = 0;
  int checked_total = 0;
  int errors = 0;
  int gap_left = 0;
  int calm_left = 0;
  int idle_cycles = 0;
  int status_tally[4] = '{0, 0, 0, 0};
  alws_pkg::out_t want;

  function automatic alws_pkg::out_t apply_list_op(alws_pkg::in_t c);
    alws_pkg::out_t r;
    alws_pkg::entry_t e;
    int idx;
    int match;
    int i;
    bit hit;
    r = '0;
    e = '0;
    idx = 0;
    hit = 1'b0;
    match = -1;
    for (i = 0; i < shadow_count; i++) begin
      if (match < 0 && shadow_entries[i].key == c.key) match = i;
    end
    case (c.kind)
      alws_pkg::KIND_INS_FRONT, alws_pkg::KIND_INS_AT, alws_pkg::KIND_APPEND: begin
        // full wins over a bad position
        if (shadow_count >= LIST_DEPTH) begin
          r.status = alws_pkg::STATUS_FULL;
        end else if (c.kind == alws_pkg::KIND_INS_AT &&
                     int'(c.position) >= shadow_count) begin
          r.status = alws_pkg::STATUS_BADPOS;
        end else begin
          if (c.kind == alws_pkg::KIND_INS_AT) idx = int'(c.position);
          else if (c.kind == alws_pkg::KIND_APPEND) idx = shadow_count;
          for (i = shadow_count; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[idx].key = c.key;
          shadow_entries[idx].price = c.price;
          shadow_entries[idx].quantity = c.quantity;
          shadow_count++;
        end
      end
      alws_pkg::KIND_REM_AT, alws_pkg::KIND_REM_KEY: begin
        if (c.kind == alws_pkg::KIND_REM_AT) begin
          if (int'(c.position) >= shadow_count) r.status = alws_pkg::STATUS_BADPOS;
          else begin
            idx = int'(c.position);
            hit = 1'b1;
          end
        end else if (match < 0) begin
          r.status = alws_pkg::STATUS_NOKEY;
        end else begin
          idx = match;
          hit = 1'b1;
        end
        if (hit) begin
          e = shadow_entries[idx];
          for (i = idx; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      alws_pkg::KIND_FIND, alws_pkg::KIND_UPD_QTY: begin
        if (match < 0) begin
          r.status = alws_pkg::STATUS_NOKEY;
        end else begin
          idx = match;
          hit = 1'b1;
          if (c.kind == alws_pkg::KIND_UPD_QTY) shadow_entries[idx].quantity = c.quantity;
          e = shadow_entries[idx];
        end
      end
      alws_pkg::KIND_READ: begin
        if (int'(c.position) >= shadow_count) r.status = alws_pkg::STATUS_BADPOS;
        else begin
          idx = int'(c.position);
          hit = 1'b1;
          e = shadow_entries[idx];
        end
      end
      alws_pkg::KIND_CLEAR: shadow_count = 0;
      default: ;
    endcase
    if (hit) begin
      r.found_index = alws_pkg::POS_W'(idx);
      r.entry_key = e.key;
      r.entry_price = e.price;
      r.entry_quantity = e.quantity;
    end
    r.entry_count = alws_pkg::CNT_OUT_W'(shadow_count);
    return r;
  endfunction

  function automatic string show(alws_pkg::out_t r);
    return $sformatf("st=%0d idx=%0d key=%h price=%h qty=%h cnt=%0d", r.status,
                     r.found_index, r.entry_key, r.entry_price, r.entry_quantity,
                     r.entry_count);
  endfunction

  task automatic queue_cmd(logic [alws_pkg::KIND_W-1:0] kind,
                           logic [alws_pkg::KEY_W-1:0] key,
                           logic [alws_pkg::PRICE_W-1:0] price,
                           logic [alws_pkg::QTY_W-1:0] qty,
                           logic [alws_pkg::POS_W-1:0] pos);
    alws_pkg::in_t c;
    c.kind = kind;
    c.key = key;
    c.price = price;
    c.quantity = qty;
    c.position = pos;
    cmd_backlog.push_back(c);
    cmd_total++;
  endtask

  function automatic alws_pkg::in_t random_cmd(bit filling);
    alws_pkg::in_t c;
    int pick;
    c.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL_N-1)]
                                         : {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) c.price = $urandom_range(0, 1) ? '1 : '0;
    else c.price = $urandom;
    if ($urandom_range(0, 9) == 0) c.quantity = $urandom_range(0, 1) ? 32'h8000_0000
                                                                     : 32'h7fff_ffff;
    else c.quantity = $urandom;
    if ($urandom_range(0, 4) == 0) c.position = alws_pkg::POS_W'($urandom_range(0, 63));
    else c.position = alws_pkg::POS_W'($urandom_range(0, LIST_DEPTH + 1));
    pick = $urandom_range(0, 99);
    if (pick < (filling ? 55 : 25)) begin
      c.kind = alws_pkg::KIND_W'($urandom_range(alws_pkg::KIND_INS_FRONT,
                                                alws_pkg::KIND_APPEND));
    end else if (pick < 65) begin
      c.kind = alws_pkg::KIND_W'($urandom_range(alws_pkg::KIND_REM_AT,
                                                alws_pkg::KIND_REM_KEY));
    end else if (pick < 95) begin
      c.kind = alws_pkg::KIND_W'($urandom_range(alws_pkg::KIND_FIND,
                                                alws_pkg::KIND_READ));
    end else if (pick < (filling ? 96 : 97)) begin
      c.kind = alws_pkg::KIND_CLEAR;
    end else begin
      c.kind = alws_pkg::KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    end
    return c;
  endfunction

  // mostly back to back, some short gaps, a few long ones, now and then a calm run
  function automatic int next_gap();
    int pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_replies.push_back(apply_list_op(in_data));
        accepted_total++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          in_data <= cmd_backlog.pop_front();
          start <= 1'b1;
          gap_left <= next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (due_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result: %s", show(out_data));
      end else begin
        want = due_replies.pop_front();
        checked_total++;
        status_tally[want.status]++;
        if (out_data.status !== want.status || out_data.found_index !== want.found_index ||
            out_data.entry_key !== want.entry_key ||
            out_data.entry_price !== want.entry_price ||
            out_data.entry_quantity !== want.entry_quantity ||
            out_data.entry_count !== want.entry_count) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("result mismatch on transaction %0d", checked_total);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(out_data));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = "ruby";
    for (int i = 4; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};

    // empty list corner cases
    queue_cmd(alws_pkg::KIND_READ, '0, '0, '0, 0);
    queue_cmd(alws_pkg::KIND_REM_AT, '0, '0, '0, 0);
    queue_cmd(alws_pkg::KIND_FIND, '1, '0, '0, 0);
    queue_cmd(alws_pkg::KIND_INS_AT, "ruby", 32'd1, 32'd1, 0);
    // fill to the brim, with a repeated key to check first match
    queue_cmd(alws_pkg::KIND_APPEND, '1, 32'hffff_ffff, 32'h8000_0000, 0);
    queue_cmd(alws_pkg::KIND_INS_FRONT, '0, '0, 32'h7fff_ffff, 63);
    queue_cmd(alws_pkg::KIND_INS_AT, "ruby", 32'd1234, -32'sd5, 1);
    queue_cmd(alws_pkg::KIND_APPEND, "blue", 32'd250, 32'd3, 0);
    queue_cmd(alws_pkg::KIND_APPEND, "ruby", 32'd999, 32'd7, 0);
    queue_cmd(alws_pkg::KIND_APPEND, "teal", 32'd10, 32'd0, 0);
    queue_cmd(alws_pkg::KIND_APPEND, "gold", 32'd77, 32'd100, 0);
    queue_cmd(alws_pkg::KIND_APPEND, "jade", 32'd5, -32'sd1, 0);
    // inserts into a full list
    queue_cmd(alws_pkg::KIND_APPEND, "onyx", 32'd1, 32'd1, 0);
    queue_cmd(alws_pkg::KIND_INS_FRONT, "onyx", 32'd1, 32'd1, 0);
    queue_cmd(alws_pkg::KIND_INS_AT, "onyx", 32'd1, 32'd1, 63);
    queue_cmd(alws_pkg::KIND_FIND, "ruby", '0, '0, 0);
    queue_cmd(alws_pkg::KIND_UPD_QTY, '1, '0, -32'sd1, 0);
    queue_cmd(alws_pkg::KIND_READ, '0, '0, '0, 7);
    queue_cmd(alws_pkg::KIND_READ, '0, '0, '0, 8);
    queue_cmd(alws_pkg::KIND_REM_KEY, '0, '0, '0, 0);
    queue_cmd(alws_pkg::KIND_REM_AT, '0, '0, '0, 63);
    queue_cmd(alws_pkg::KIND_REM_AT, '0, '0, '0, 6);
    queue_cmd(KIND_UNUSED_LO, '1, '1, '1, 63);
    queue_cmd(KIND_UNUSED_HI, '1, '1, '1, 63);
    queue_cmd(alws_pkg::KIND_CLEAR, '0, '0, '0, 0);
    queue_cmd(alws_pkg::KIND_UPD_QTY, "ruby", '0, 32'd9, 0);

    // alternate stretches that tend to fill and drain the list
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      cmd_backlog.push_back(random_cmd(((n / 64) % 2) == 0));
      cmd_total++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_total != cmd_total || due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results checked against the shadow list",
             accepted_total, checked_total);
    $display("statuses seen: ok %0d, full %0d, bad position %0d, key missing %0d",
             status_tally[alws_pkg::STATUS_OK], status_tally[alws_pkg::STATUS_FULL],
             status_tally[alws_pkg::STATUS_BADPOS], status_tally[alws_pkg::STATUS_NOKEY]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
